// ----- src/e2ck_pkg.sv -----
`default_nettype none

package e2ck_pkg;

	localparam int ANGLE_BITS        = 32;
	localparam int FRACTION_BITS     = 30;
	localparam int CORDIC_STAGES_DEF = 32;

	localparam int HALF_BITS  = ANGLE_BITS + 1;
	localparam int REM_BITS   = HALF_BITS - 2;
	localparam int QB         = 60;
	localparam int CW         = QB + 2;
	localparam int MAG_BITS   = QB + 1;
	localparam int OUT_BITS   = FRACTION_BITS + 2;
	// input register, angle scaling (2), quadrant, multiplier (3), select, round
	localparam int PIPE_EXTRA = 9;

	localparam logic [63:0] PI4_Q60    = 64'h0C90FDAA22168C23;
	localparam logic [63:0] PI2_Q60    = 64'h1921FB54442D1846;
	localparam logic [63:0] RSQRT2_Q60 = 64'h0B504F333F9DE648;

	typedef logic signed [CW-1:0] q60_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] first_angle;
		logic [ANGLE_BITS-1:0] middle_angle;
		logic [ANGLE_BITS-1:0] third_angle;
	} e2ck_in_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] a_real;
		logic signed [OUT_BITS-1:0] a_imag;
		logic signed [OUT_BITS-1:0] b_real;
		logic signed [OUT_BITS-1:0] b_imag;
	} e2ck_out_t;

	// restoring division, elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// arctan(2^-i) in Q60, truncated power series
	function automatic logic [63:0] atan_q60(int i);
		logic [63:0] sum;
		logic [63:0] t;
		sum = '0;
		if (i == 0) begin
			sum = PI4_Q60;
		end else begin
			for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
				t = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
				if ((k % 2) == 1) begin
					sum = sum - t;
				end else begin
					sum = sum + t;
				end
			end
		end
		return sum;
	endfunction

	// CORDIC start value: product of 1/sqrt(1+2^-2i) in Q60
	function automatic logic [63:0] cordic_gain(int n);
		logic [63:0] g;
		logic [63:0] sum;
		logic [63:0] c;
		logic [63:0] t;
		g = RSQRT2_Q60;
		for (int i = 1; i < n; i++) begin
			sum = '0;
			c   = 64'd1;
			for (int k = 0; 2 * k * (i + 1) < 64; k++) begin
				if (k > 0) begin
					c = udiv64(c * 64'd2 * 64'(2 * k - 1), 64'(k));
				end
				t = c * (g >> (2 * k * (i + 1)));
				if ((k % 2) == 1) begin
					sum = sum - t;
				end else begin
					sum = sum + t;
				end
			end
			g = sum;
		end
		return g;
	endfunction

endpackage

`default_nettype wire

// ----- src/e2ck_sincos.sv -----
`default_nettype none

module e2ck_sincos #(
	parameter int CORDIC_STAGES = e2ck_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [e2ck_pkg::HALF_BITS-1:0] angle,
	output logic                          out_valid,
	output e2ck_pkg::q60_t                cos_val,
	output e2ck_pkg::q60_t                sin_val
);
	import e2ck_pkg::*;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam int RLO = (REM_BITS + 1) / 2;
	localparam int RHI = REM_BITS - RLO;
	localparam int PLO = 32;
	localparam int PHI = MAG_BITS - PLO;
	localparam int PW  = REM_BITS + MAG_BITS;

	localparam logic [PLO-1:0] PI2_LO = PI2_Q60[PLO-1:0];
	localparam logic [PHI-1:0] PI2_HI = PI2_Q60[MAG_BITS-1:PLO];

	localparam logic [63:0] GAIN64 = cordic_gain(CORDIC_STAGES);
	localparam q60_t GAIN    = GAIN64[CW-1:0];
	localparam q60_t ONE_Q   = {2'b01, {QB{1'b0}}};
	localparam q60_t NEG_ONE = -ONE_Q;

	function automatic q60_t clamp_one(q60_t v);
		q60_t r;
		r = v;
		if (v > ONE_Q) begin
			r = ONE_Q;
		end else if (v < NEG_ONE) begin
			r = NEG_ONE;
		end
		return r;
	endfunction

	// angle remainder times pi/2, as partial products
	logic [RLO-1:0] r_lo;
	logic [RHI-1:0] r_hi;
	assign r_lo = angle[RLO-1:0];
	assign r_hi = angle[REM_BITS-1:RLO];

	logic                   v_s1;
	logic [1:0]             quad_s1;
	logic [RLO+PLO-1:0]     pp_ll_s1;
	logic [RLO+PHI-1:0]     pp_lh_s1;
	logic [RHI+PLO-1:0]     pp_hl_s1;
	logic [RHI+PHI-1:0]     pp_hh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			quad_s1  <= angle[HALF_BITS-1:HALF_BITS-2];
			pp_ll_s1 <= r_lo * PI2_LO;
			pp_lh_s1 <= r_lo * PI2_HI;
			pp_hl_s1 <= r_hi * PI2_LO;
			pp_hh_s1 <= r_hi * PI2_HI;
		end
	end

	logic [PW-1:0] rad_full;
	assign rad_full = PW'(pp_ll_s1) + (PW'(pp_lh_s1) << PLO) + (PW'(pp_hl_s1) << RLO)
		+ (PW'(pp_hh_s1) << (PLO + RLO));

	logic       v_s2;
	logic [1:0] quad_s2;
	q60_t       z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			quad_s2 <= quad_s1;
			z_s2    <= {1'b0, rad_full[PW-1:REM_BITS]};
		end
	end

	// one CORDIC iteration per stage
	q60_t       x_s    [0:CORDIC_STAGES-1];
	q60_t       y_s    [0:CORDIC_STAGES-1];
	q60_t       z_s    [0:CORDIC_STAGES-1];
	logic [1:0] quad_s [0:CORDIC_STAGES-1];
	logic       vld_s  [0:CORDIC_STAGES-1];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		localparam logic [63:0] AT64 = atan_q60(i);
		localparam q60_t        AT   = AT64[CW-1:0];

		q60_t       x_in;
		q60_t       y_in;
		q60_t       z_in;
		logic [1:0] q_in;
		logic       v_in;

		if (i == 0) begin : g_first
			assign x_in = GAIN;
			assign y_in = '0;
			assign z_in = z_s2;
			assign q_in = quad_s2;
			assign v_in = v_s2;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign z_in = z_s[i-1];
			assign q_in = quad_s[i-1];
			assign v_in = vld_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (v_in) begin
				quad_s[i] <= q_in;
				if (!z_in[CW-1]) begin
					x_s[i] <= x_in - (y_in >>> i);
					y_s[i] <= y_in + (x_in >>> i);
					z_s[i] <= z_in - AT;
				end else begin
					x_s[i] <= x_in + (y_in >>> i);
					y_s[i] <= y_in - (x_in >>> i);
					z_s[i] <= z_in + AT;
				end
			end
		end
	end

	q60_t c_cl;
	q60_t s_cl;
	q60_t cos_nx;
	q60_t sin_nx;
	assign c_cl = clamp_one(x_s[CORDIC_STAGES-1]);
	assign s_cl = clamp_one(y_s[CORDIC_STAGES-1]);

	always_comb begin
		unique case (quad_s[CORDIC_STAGES-1])
			QUAD_0: begin
				cos_nx = c_cl;
				sin_nx = s_cl;
			end
			QUAD_1: begin
				cos_nx = -s_cl;
				sin_nx = c_cl;
			end
			QUAD_2: begin
				cos_nx = -c_cl;
				sin_nx = -s_cl;
			end
			QUAD_3: begin
				cos_nx = s_cl;
				sin_nx = -c_cl;
			end
		endcase
	end

	logic v_sq;
	q60_t cos_sq;
	q60_t sin_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq <= 1'b0;
		end else begin
			v_sq <= vld_s[CORDIC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[CORDIC_STAGES-1]) begin
			cos_sq <= cos_nx;
			sin_sq <= sin_nx;
		end
	end

	assign out_valid = v_sq;
	assign cos_val   = cos_sq;
	assign sin_val   = sin_sq;

endmodule

`default_nettype wire

// ----- src/e2ck_qmul.sv -----
`default_nettype none

module e2ck_qmul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  e2ck_pkg::q60_t a,
	input  e2ck_pkg::q60_t b,
	output logic           out_valid,
	output e2ck_pkg::q60_t prod
);
	import e2ck_pkg::*;

	localparam int LW = (MAG_BITS + 1) / 2;
	localparam int HW = MAG_BITS - LW;
	localparam int SW = 2 * MAG_BITS;

	q60_t abs_a;
	q60_t abs_b;
	assign abs_a = a[CW-1] ? -a : a;
	assign abs_b = b[CW-1] ? -b : b;

	logic                v_s1;
	logic                neg_s1;
	logic [MAG_BITS-1:0] ma_s1;
	logic [MAG_BITS-1:0] mb_s1;

	logic                v_s2;
	logic                neg_s2;
	logic [2*LW-1:0]     ll_s2;
	logic [LW+HW-1:0]    lh_s2;
	logic [LW+HW-1:0]    hl_s2;
	logic [2*HW-1:0]     hh_s2;

	logic                v_s3;
	q60_t                prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			neg_s1 <= a[CW-1] ^ b[CW-1];
			ma_s1  <= abs_a[MAG_BITS-1:0];
			mb_s1  <= abs_b[MAG_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			neg_s2 <= neg_s1;
			ll_s2  <= ma_s1[LW-1:0] * mb_s1[LW-1:0];
			lh_s2  <= ma_s1[LW-1:0] * mb_s1[MAG_BITS-1:LW];
			hl_s2  <= ma_s1[MAG_BITS-1:LW] * mb_s1[LW-1:0];
			hh_s2  <= ma_s1[MAG_BITS-1:LW] * mb_s1[MAG_BITS-1:LW];
		end
	end

	logic [SW-1:0] full;
	q60_t          mag;
	assign full = SW'(ll_s2) + (SW'(lh_s2) << LW) + (SW'(hl_s2) << LW)
		+ (SW'(hh_s2) << (2 * LW));
	assign mag  = {1'b0, full[QB +: MAG_BITS]};

	always_ff @(posedge clk) begin
		if (v_s2) begin
			prod_s3 <= neg_s2 ? -mag : mag;
		end
	end

	assign out_valid = v_s3;
	assign prod      = prod_s3;

endmodule

`default_nettype wire

// ----- src/euler_to_cayley_klein.sv -----
// Channel  Signals                   Transfer
// input    start, busy, angles       start high, busy low at rising clk
// config   cfg_wr_en, cfg_wr_data    cfg_wr_en high at rising clk
// result   done, result              done high for one cycle, always taken
//
// Accepts one item every cycle; busy never rises.
// The path runs through the input register, angle scaling, the CORDIC pipeline
// (one stage per iteration), quadrant select, the split multipliers, select and round.
// arst_n clears all valid bits and rotation_sequence (3-2-3).
// The receiver cannot stall, so the pipeline only advances.
`default_nettype none

module euler_to_cayley_klein #(
	parameter int CORDIC_STAGES = e2ck_pkg::CORDIC_STAGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  e2ck_pkg::e2ck_in_t  angles,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	output logic                done,
	output e2ck_pkg::e2ck_out_t result
);
	import e2ck_pkg::*;

	localparam q60_t RND = q60_t'(64'd1 << (QB - FRACTION_BITS - 1));
	localparam logic signed [OUT_BITS-1:0] LIM  = {2'b01, {FRACTION_BITS{1'b0}}};
	localparam logic signed [OUT_BITS-1:0] NLIM = -LIM;

	function automatic logic signed [OUT_BITS-1:0] round_out(q60_t v);
		q60_t                       t;
		logic signed [OUT_BITS-1:0] r;
		t = v + RND;
		r = t[CW-1:QB-FRACTION_BITS];
		if (r > LIM) begin
			r = LIM;
		end else if (r < NLIM) begin
			r = NLIM;
		end
		return r;
	endfunction

	logic rot_seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_seq_q <= 1'b0;
		end else if (cfg_wr_en) begin
			rot_seq_q <= cfg_wr_data;
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// half angles at ANGLE_BITS+1 bits
	logic                 v_s1;
	logic [HALF_BITS-1:0] sum_s1;
	logic [HALF_BITS-1:0] dif_s1;
	logic [HALF_BITS-1:0] mid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1 <= {1'b0, angles.first_angle} + {1'b0, angles.third_angle};
			dif_s1 <= {1'b0, angles.first_angle} - {1'b0, angles.third_angle};
			mid_s1 <= {1'b0, angles.middle_angle};
		end
	end

	logic v_al;
	logic v_be;
	logic v_h;
	q60_t ca;
	q60_t sa;
	q60_t cb;
	q60_t sb;
	q60_t ch;
	q60_t sh;

	e2ck_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.angle    (sum_s1),
		.out_valid(v_al),
		.cos_val  (ca),
		.sin_val  (sa)
	);

	e2ck_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_dif (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.angle    (dif_s1),
		.out_valid(v_be),
		.cos_val  (cb),
		.sin_val  (sb)
	);

	e2ck_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.angle    (mid_s1),
		.out_valid(v_h),
		.cos_val  (ch),
		.sin_val  (sh)
	);

	logic v_trig;
	assign v_trig = v_al & v_be & v_h;

	logic v_m0;
	logic v_m1;
	logic v_m2;
	logic v_m3;
	q60_t p_ar;
	q60_t p_ai;
	q60_t p_cs;
	q60_t p_ss;

	e2ck_qmul u_mul_ar (
		.clk(clk), .arst_n(arst_n), .in_valid(v_trig),
		.a(ca), .b(ch), .out_valid(v_m0), .prod(p_ar)
	);

	e2ck_qmul u_mul_ai (
		.clk(clk), .arst_n(arst_n), .in_valid(v_trig),
		.a(sa), .b(ch), .out_valid(v_m1), .prod(p_ai)
	);

	e2ck_qmul u_mul_cs (
		.clk(clk), .arst_n(arst_n), .in_valid(v_trig),
		.a(cb), .b(sh), .out_valid(v_m2), .prod(p_cs)
	);

	e2ck_qmul u_mul_ss (
		.clk(clk), .arst_n(arst_n), .in_valid(v_trig),
		.a(sb), .b(sh), .out_valid(v_m3), .prod(p_ss)
	);

	logic v_mul;
	assign v_mul = v_m0 & v_m1 & v_m2 & v_m3;

	// sequence select: 3-2-3 gives B = -(cb, sb) sh, 3-1-3 gives B = (-sb, cb) sh
	logic v_s2;
	q60_t ar_s2;
	q60_t ai_s2;
	q60_t br_s2;
	q60_t bi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_mul;
		end
	end

	always_ff @(posedge clk) begin
		if (v_mul) begin
			ar_s2 <= p_ar;
			ai_s2 <= p_ai;
			br_s2 <= rot_seq_q ? -p_ss : -p_cs;
			bi_s2 <= rot_seq_q ? p_cs : -p_ss;
		end
	end

	logic      v_s3;
	e2ck_out_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			res_s3.a_real <= round_out(ar_s2);
			res_s3.a_imag <= round_out(ai_s2);
			res_s3.b_real <= round_out(br_s2);
			res_s3.b_imag <= round_out(bi_s2);
		end
	end

	assign done   = v_s3;
	assign result = res_s3;

endmodule

`default_nettype wire

// ----- src/e2ck_checker.sv -----
`default_nettype none

module e2ck_checker #(
	parameter int CORDIC_STAGES = e2ck_pkg::CORDIC_STAGES_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input e2ck_pkg::e2ck_out_t result
);
	import e2ck_pkg::*;

	localparam int LATENCY = CORDIC_STAGES + PIPE_EXTRA;
	localparam int CNT_W   = $clog2(LATENCY + 1);
	localparam logic signed [OUT_BITS-1:0] LIM  = {2'b01, {FRACTION_BITS{1'b0}}};
	localparam logic signed [OUT_BITS-1:0] NLIM = -LIM;

	// cycles since reset release, saturating
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_q != CNT_W'(LATENCY)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy asserted");

	a_one_result_per_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CNT_W'(LATENCY)) |-> (done == $past(start && !busy, LATENCY)))
		else $error("result strobe does not match accepted transfer");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.a_real <= LIM && result.a_real >= NLIM
			&& result.a_imag <= LIM && result.a_imag >= NLIM
			&& result.b_real <= LIM && result.b_real >= NLIM
			&& result.b_imag <= LIM && result.b_imag >= NLIM))
		else $error("result outside +-1.0");

endmodule

bind euler_to_cayley_klein e2ck_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_e2ck_checker (.*);

`default_nettype wire
